### rtl/core/uccp_pkg.sv
// uccp_pkg: types, codes and constants of the uart command packet parser
// depends on nothing; imported by every other file of the block
`timescale 1ns / 1ps

package uccp_pkg;

    // text buffer geometry
    localparam int BUFFER_DEPTH = 64;
    localparam int CNT_W        = $clog2(BUFFER_DEPTH);

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_PREFIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_PREFIX   = 2'd1;
    localparam logic [7:0] BINARY_PREFIX_RST = 8'd33;
    localparam logic [7:0] TEXT_PREFIX_RST   = 8'd36;

    // characters that carry meaning
    localparam logic [7:0] CHR_C  = 8'h43;
    localparam logic [7:0] CHR_B  = 8'h42;
    localparam logic [7:0] CHR_NL = 8'h0A;
    localparam logic [7:0] CHR_0  = 8'h30;
    localparam logic [7:0] CHR_1  = 8'h31;

    // result kinds
    typedef enum logic [2:0] {
        KIND_COLOUR = 3'd0,
        KIND_BUTTON = 3'd1,
        KIND_CHAR   = 3'd2,
        KIND_END    = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_PREFIX   = 2'd0,
        ERR_CODE     = 2'd1,
        ERR_CHECKSUM = 2'd2
    } err_t;

    // parser phase of the front
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CODE,
        PH_BIN,
        PH_TEXT
    } phase_t;

    // back sequencer state
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_WAIT
    } back_state_t;

    // command kinds passed through the queue
    typedef enum logic [1:0] {
        CMD_COLOUR,
        CMD_BUTTON,
        CMD_ERROR,
        CMD_TEXT
    } cmd_kind_t;

    // one command: colour bytes or button fields, error code or text length
    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        err_t             err;
        logic [CNT_W-1:0] len;
    } cmd_t;

    // front push into the queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_push_t;

    // front write into the text buffer
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    // one result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] button_number;
        logic       pressed;
        logic [7:0] text_char;
        err_t       error_code;
        logic       last;
    } result_t;

endpackage

### rtl/core/uccp_ifs.sv
// uccp channel interfaces: received byte, result item and configuration write
// depends on uccp_pkg
`timescale 1ns / 1ps

interface uccp_rx_if;
    import uccp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface uccp_res_if;
    import uccp_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] button_number;
    logic       pressed;
    logic [7:0] text_char;
    logic [1:0] error_code;
    logic       last;
    modport source (output valid, output kind, output red, output green, output blue,
                    output button_number, output pressed, output text_char,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input red, input green, input blue,
                    input button_number, input pressed, input text_char,
                    input error_code, input last, output ready);
endinterface

interface uccp_cfg_if;
    import uccp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/uccp_front.sv
// uccp_front: takes received bytes, tracks the packet phase, checks checksums,
// fills the text buffer and pushes one command per finished packet or error
// depends on uccp_pkg and uccp_ifs
`timescale 1ns / 1ps

module uccp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    uccp_rx_if.sink                 rx,
    uccp_cfg_if.sink                cfg,
    input  uccp_pkg::fifo_status_t  fifo_status,
    input  logic                    text_done,
    output uccp_pkg::cmd_push_t     cmd_push,
    output uccp_pkg::mem_wr_t       mem_wr
);
    import uccp_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             is_button_reg, is_button_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       d0_reg, d0_next;
    logic [7:0]       d1_reg, d1_next;
    logic [7:0]       d2_reg, d2_next;
    logic             zero_seen_reg, zero_seen_next;
    logic [CNT_W-1:0] zero_pos_reg, zero_pos_next;
    logic             hold_reg, hold_next;
    logic [7:0]       bin_prefix_reg;
    logic [7:0]       text_prefix_reg;

    logic [CNT_W:0]   text_cnt;
    logic [1:0]       need;
    logic             accept;
    logic [7:0]       b;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_prefix_reg  <= BINARY_PREFIX_RST;
            text_prefix_reg <= TEXT_PREFIX_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BINARY_PREFIX: bin_prefix_reg  <= cfg.data;
                REG_TEXT_PREFIX:   text_prefix_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // input stalls on a full queue or while a text flush owns the buffer
    assign rx.ready = !fifo_status.full && !hold_reg;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign need     = is_button_reg ? 2'd2 : 2'd3;
    assign text_cnt = {1'b0, count_reg} + 1'b1;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            is_button_reg <= 1'b0;
            sum_reg       <= '0;
            zero_seen_reg <= 1'b0;
            zero_pos_reg  <= '0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            is_button_reg <= is_button_next;
            sum_reg       <= sum_next;
            zero_seen_reg <= zero_seen_next;
            zero_pos_reg  <= zero_pos_next;
            hold_reg      <= hold_next;
        end
    end

    // packet data bytes
    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
        d2_reg <= d2_next;
    end

    // parser next state and commands
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        is_button_next = is_button_reg;
        sum_next       = sum_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        zero_seen_next = zero_seen_reg;
        zero_pos_next  = zero_pos_reg;
        hold_next      = hold_reg;
        cmd_push       = '0;
        mem_wr         = '0;

        if (text_done)
        begin
            hold_next = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == bin_prefix_reg)
                    begin
                        sum_next   = b;
                        phase_next = PH_CODE;
                    end
                    else if (b == text_prefix_reg)
                    begin
                        count_next     = '0;
                        zero_seen_next = 1'b0;
                        zero_pos_next  = '0;
                        phase_next     = PH_TEXT;
                    end
                    else
                    begin
                        cmd_push.push     = 1'b1;
                        cmd_push.cmd.kind = CMD_ERROR;
                        cmd_push.cmd.err  = ERR_PREFIX;
                    end
                end

                PH_CODE:
                begin
                    if (b == CHR_C || b == CHR_B)
                    begin
                        is_button_next = (b == CHR_B);
                        sum_next       = sum_reg + b;
                        count_next     = '0;
                        phase_next     = PH_BIN;
                    end
                    else
                    begin
                        cmd_push.push     = 1'b1;
                        cmd_push.cmd.kind = CMD_ERROR;
                        cmd_push.cmd.err  = ERR_CODE;
                        phase_next        = PH_IDLE;
                        is_button_next    = 1'b0;
                        sum_next          = '0;
                    end
                end

                PH_BIN:
                begin
                    if (count_reg < CNT_W'(need))
                    begin
                        // collect a data byte
                        case (count_reg[1:0])
                            2'd0:    d0_next = b;
                            2'd1:    d1_next = b;
                            default: d2_next = b;
                        endcase
                        sum_next   = sum_reg + b;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        // checksum byte ends the packet
                        cmd_push.push = 1'b1;
                        if (b != ~sum_reg)
                        begin
                            cmd_push.cmd.kind = CMD_ERROR;
                            cmd_push.cmd.err  = ERR_CHECKSUM;
                        end
                        else if (is_button_reg)
                        begin
                            cmd_push.cmd.kind = CMD_BUTTON;
                            cmd_push.cmd.b0   = d0_reg - CHR_0 - 8'd1;
                            cmd_push.cmd.b1   = {7'd0, d1_reg == CHR_1};
                        end
                        else
                        begin
                            cmd_push.cmd.kind = CMD_COLOUR;
                            cmd_push.cmd.b0   = d0_reg;
                            cmd_push.cmd.b1   = d1_reg;
                            cmd_push.cmd.b2   = d2_reg;
                        end
                        phase_next     = PH_IDLE;
                        count_next     = '0;
                        is_button_next = 1'b0;
                        sum_next       = '0;
                    end
                end

                default:
                begin
                    if (b == CHR_NL)
                    begin
                        // newline: characters end at the first zero byte or here
                        cmd_push.push     = 1'b1;
                        cmd_push.cmd.kind = CMD_TEXT;
                        cmd_push.cmd.len  = zero_seen_reg ? zero_pos_reg : count_reg;
                        hold_next         = 1'b1;
                        phase_next        = PH_IDLE;
                        count_next        = '0;
                    end
                    else
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = count_reg;
                        mem_wr.data = b;
                        if (b == 8'd0 && !zero_seen_reg)
                        begin
                            zero_seen_next = 1'b1;
                            zero_pos_next  = count_reg;
                        end
                        if (text_cnt >= (CNT_W + 1)'(BUFFER_DEPTH))
                        begin
                            // buffer full: last stored byte counts as the terminator
                            cmd_push.push     = 1'b1;
                            cmd_push.cmd.kind = CMD_TEXT;
                            cmd_push.cmd.len  = zero_seen_next ? zero_pos_next
                                                               : CNT_W'(BUFFER_DEPTH - 1);
                            hold_next         = 1'b1;
                            phase_next        = PH_IDLE;
                            count_next        = '0;
                        end
                        else
                        begin
                            count_next = text_cnt[CNT_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

endmodule

### rtl/core/uccp_cmd_fifo.sv
// uccp_cmd_fifo: short command queue between the parser front and the result back
// depends on uccp_pkg
`timescale 1ns / 1ps

module uccp_cmd_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  uccp_pkg::cmd_push_t     cmd_push,
    input  logic                    pop,
    output uccp_pkg::cmd_t          head,
    output uccp_pkg::fifo_status_t  status
);
    import uccp_pkg::*;

    cmd_t                 entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign head         = entry_reg[rd_ptr_reg];
    assign do_push      = cmd_push.push && !status.full;
    assign do_pop       = pop && !status.empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_push.cmd;
        end
    end

endmodule

### rtl/core/uccp_back.sv
// uccp_back: carries out queued commands, holds the text buffer memory and
// drives the result channel from an output register
// depends on uccp_pkg and uccp_ifs
`timescale 1ns / 1ps

module uccp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  uccp_pkg::mem_wr_t       mem_wr,
    input  uccp_pkg::cmd_t          head,
    input  uccp_pkg::fifo_status_t  fifo_status,
    output logic                    pop,
    output logic                    text_done,
    uccp_res_if.source              result
);
    import uccp_pkg::*;

    logic [7:0]       mem [BUFFER_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             rd_en;
    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg;
    result_t          load_data;
    logic             load;
    logic             out_free;

    // text buffer: front writes, sequencer reads with a registered port
    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign out_free = !out_valid_reg || result.ready;

    // sequencer next state and result loading
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        pop        = 1'b0;
        load       = 1'b0;
        load_data  = '0;
        rd_en      = 1'b0;
        text_done  = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_status.empty && out_free)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        CMD_COLOUR:
                        begin
                            load            = 1'b1;
                            load_data.kind  = KIND_COLOUR;
                            load_data.red   = head.b0;
                            load_data.green = head.b1;
                            load_data.blue  = head.b2;
                            load_data.last  = 1'b1;
                        end
                        CMD_BUTTON:
                        begin
                            load                    = 1'b1;
                            load_data.kind          = KIND_BUTTON;
                            load_data.button_number = head.b0;
                            load_data.pressed       = head.b1[0];
                            load_data.last          = 1'b1;
                        end
                        CMD_ERROR:
                        begin
                            load                 = 1'b1;
                            load_data.kind       = KIND_ERROR;
                            load_data.error_code = head.err;
                            load_data.last       = 1'b1;
                        end
                        default:
                        begin
                            len_next   = head.len;
                            idx_next   = '0;
                            state_next = BK_FETCH;
                        end
                    endcase
                end
            end

            BK_FETCH:
            begin
                if (idx_reg == len_reg)
                begin
                    // all characters out: end marker frees the buffer
                    if (out_free)
                    begin
                        load           = 1'b1;
                        load_data.kind = KIND_END;
                        load_data.last = 1'b1;
                        text_done      = 1'b1;
                        state_next     = BK_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = BK_WAIT;
                end
            end

            BK_WAIT:
            begin
                if (out_free)
                begin
                    load                = 1'b1;
                    load_data.kind      = KIND_CHAR;
                    load_data.text_char = rd_data_reg;
                    idx_next            = idx_reg + 1'b1;
                    state_next          = BK_FETCH;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= load_data;
        end
    end

    // result channel
    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.red           = out_reg.red;
    assign result.green         = out_reg.green;
    assign result.blue          = out_reg.blue;
    assign result.button_number = out_reg.button_number;
    assign result.pressed       = out_reg.pressed;
    assign result.text_char     = out_reg.text_char;
    assign result.error_code    = out_reg.error_code;
    assign result.last          = out_reg.last;

endmodule

### rtl/core/uart_command_packet_parser_core.sv
// a colour, button or error result is registered in the command queue, then in the output register
// text: the ending byte queues the command; the sequencer then reads each character from the
// buffer and loads it into the output register (buffer read then output load), end marker last
// throughput: one byte per cycle, except that input stalls on a full queue or a text flush
// reset: rst_n clears phase, queue, sequencer and prefixes (33, 36); buffer is not cleared
`timescale 1ns / 1ps

module uart_command_packet_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    uccp_rx_if.sink     rx,
    uccp_cfg_if.sink    cfg,
    uccp_res_if.source  result
);
    import uccp_pkg::*;

    cmd_push_t    cmd_push;
    mem_wr_t      mem_wr;
    cmd_t         head;
    fifo_status_t fifo_status;
    logic         pop;
    logic         text_done;

    // parser front
    uccp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx),
        .cfg         (cfg),
        .fifo_status (fifo_status),
        .text_done   (text_done),
        .cmd_push    (cmd_push),
        .mem_wr      (mem_wr)
    );

    // command queue
    uccp_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_push (cmd_push),
        .pop      (pop),
        .head     (head),
        .status   (fifo_status)
    );

    // result back
    uccp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_wr      (mem_wr),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .text_done   (text_done),
        .result      (result)
    );

endmodule

### bench/uart_command_packet_parser_core_tb.sv
// uart_command_packet_parser_core_tb: self-checking bench of the command packet parser
// depends on uccp_pkg, the uccp channel interfaces and uart_command_packet_parser_core
// predicts every result item from the received bytes and checks them in order
`timescale 1ns / 1ps

module uart_command_packet_parser_core_tb;
    import uccp_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int QUIET_CYCLES = 16;

    logic clk;
    logic rst_n;

    uccp_rx_if  rx_ch ();
    uccp_cfg_if cfg_ch ();
    uccp_res_if res_ch ();

    uart_command_packet_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .cfg    (cfg_ch),
        .result (res_ch)
    );

    // predicted parser state and configuration
    phase_t     parse_phase;
    logic [5:0] collected;
    bit         is_button;
    logic [7:0] sum_acc;
    logic [7:0] text_buf [BUFFER_DEPTH];
    logic [7:0] bin_prefix;
    logic [7:0] txt_prefix;

    result_t pending_results [$];
    int      fail_count;
    int      sent_items;
    int      cycle_count;
    int      rx_gap_pct;
    int      res_stall_pct;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("uart_command_packet_parser_core: mismatch");
            $finish;
        end
    end

    function automatic result_t blank_result(kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic void go_idle();
        parse_phase = PH_IDLE;
        collected   = '0;
        is_button   = 1'b0;
        sum_acc     = '0;
    endfunction

    function automatic void push_error(err_t code);
        result_t r;
        r = blank_result(KIND_ERROR);
        r.error_code = code;
        r.last = 1'b1;
        pending_results.push_back(r);
        go_idle();
    endfunction

    // text is emitted up to the first zero byte, then the end marker
    function automatic void flush_text();
        result_t r;
        for (int i = 0; i < BUFFER_DEPTH - 1; i++)
        begin
            if (text_buf[i] == 8'h00)
                break;
            r = blank_result(KIND_CHAR);
            r.text_char = text_buf[i];
            pending_results.push_back(r);
        end
        r = blank_result(KIND_END);
        r.last = 1'b1;
        pending_results.push_back(r);
        go_idle();
    endfunction

    // expected results of one accepted byte
    function automatic void predict_byte(logic [7:0] b);
        result_t    r;
        logic [5:0] need;
        int         cnt;
        case (parse_phase)
            PH_IDLE:
            begin
                // binary path wins when both prefixes match
                if (b == bin_prefix)
                begin
                    sum_acc     = b;
                    parse_phase = PH_CODE;
                end
                else if (b == txt_prefix)
                begin
                    collected   = '0;
                    parse_phase = PH_TEXT;
                end
                else
                    push_error(ERR_PREFIX);
            end
            PH_CODE:
            begin
                if (b != CHR_C && b != CHR_B)
                    push_error(ERR_CODE);
                else
                begin
                    is_button   = (b == CHR_B);
                    sum_acc     = sum_acc + b;
                    collected   = '0;
                    parse_phase = PH_BIN;
                end
            end
            PH_BIN:
            begin
                need = is_button ? 6'd2 : 6'd3;
                if (collected < need)
                begin
                    text_buf[collected] = b;
                    sum_acc   = sum_acc + b;
                    collected = collected + 6'd1;
                end
                else if (b != ~sum_acc)
                    push_error(ERR_CHECKSUM);
                else
                begin
                    if (is_button)
                    begin
                        r = blank_result(KIND_BUTTON);
                        r.button_number = text_buf[0] - CHR_0 - 8'd1;
                        r.pressed = (text_buf[1] == CHR_1);
                    end
                    else
                    begin
                        r = blank_result(KIND_COLOUR);
                        r.red   = text_buf[0];
                        r.green = text_buf[1];
                        r.blue  = text_buf[2];
                    end
                    r.last = 1'b1;
                    pending_results.push_back(r);
                    go_idle();
                end
            end
            default:
            begin
                cnt = collected;
                if (b == CHR_NL)
                begin
                    text_buf[cnt] = 8'h00;
                    flush_text();
                end
                else
                begin
                    text_buf[cnt] = b;
                    cnt++;
                    // buffer full: last byte replaced by zero, text emitted at once
                    if (cnt >= BUFFER_DEPTH)
                    begin
                        text_buf[BUFFER_DEPTH-1] = 8'h00;
                        flush_text();
                    end
                    else
                        collected = 6'(cnt);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker and random receiver stall
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result item with none expected: kind %0d", res_ch.kind);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(res_ch.kind));
                check_field("red", want.red, res_ch.red);
                check_field("green", want.green, res_ch.green);
                check_field("blue", want.blue, res_ch.blue);
                check_field("button_number", want.button_number, res_ch.button_number);
                check_field("pressed", 8'(want.pressed), 8'(res_ch.pressed));
                check_field("text_char", want.text_char, res_ch.text_char);
                check_field("error_code", 8'(want.error_code), 8'(res_ch.error_code));
                check_field("last", 8'(want.last), 8'(res_ch.last));
            end
        end
        res_ch.ready <= ($urandom_range(99) >= res_stall_pct);
    end

    // send one byte with random gaps before it, valid stays high afterwards
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < rx_gap_pct)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        predict_byte(b);
        sent_items++;
    endtask

    // stop sending and let every expected result come out
    task automatic wait_quiet();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // write both prefix registers, block idle
    task automatic set_prefixes(input logic [7:0] bp, input logic [7:0] tp);
        logic [7:0] vals [2];
        vals[0] = bp;
        vals[1] = tp;
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 2; i++)
        begin
            cfg_ch.index <= (i == 0) ? REG_BINARY_PREFIX : REG_TEXT_PREFIX;
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        bin_prefix = bp;
        txt_prefix = tp;
    endtask

    // bring the parser back to idle with the fewest bytes
    task automatic return_to_idle();
        logic [7:0] b;
        while (parse_phase != PH_IDLE)
        begin
            case (parse_phase)
                PH_TEXT: b = CHR_NL;
                PH_CODE:
                begin
                    do b = 8'($urandom); while (b == CHR_C || b == CHR_B);
                end
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CHR_NL);
        return b;
    endfunction

    // full binary packet, checksum optionally broken in one bit
    task automatic send_binary(input logic [7:0] code, input logic [7:0] d0,
                               input logic [7:0] d1, input logic [7:0] d2, input bit corrupt);
        logic [7:0] chk;
        chk = bin_prefix + code + d0 + d1;
        if (code == CHR_C)
            chk = chk + d2;
        chk = ~chk;
        if (corrupt)
            chk = chk ^ (8'd1 << $urandom_range(7));
        send_byte(bin_prefix);
        send_byte(code);
        send_byte(d0);
        send_byte(d1);
        if (code == CHR_C)
            send_byte(d2);
        send_byte(chk);
    endtask

    // text command of given length, newline only if still collecting
    task automatic send_text(input int len);
        send_byte(txt_prefix);
        for (int i = 0; i < len; i++)
            send_byte(text_byte());
        if (parse_phase == PH_TEXT)
            send_byte(CHR_NL);
    endtask

    task automatic test_binary_packets();
        send_binary(CHR_C, 8'h00, 8'hFF, 8'h80, 1'b0);
        send_binary(CHR_B, CHR_0, CHR_1, 8'h00, 1'b0);
        wait_quiet();
    endtask

    task automatic test_packet_errors();
        // unknown prefix, unknown code, bad checksum
        send_byte(8'h00);
        send_byte(bin_prefix);
        send_byte(8'hFF);
        send_binary(CHR_B, 8'h39, 8'h30, 8'h00, 1'b1);
        wait_quiet();
    endtask

    task automatic test_text_commands();
        // empty text, then text cut at a zero byte
        send_byte(txt_prefix);
        send_byte(CHR_NL);
        send_byte(txt_prefix);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'h42);
        send_byte(CHR_NL);
        wait_quiet();
    endtask

    task automatic test_equal_prefixes();
        set_prefixes(CHR_C, CHR_C);
        send_binary(CHR_C, 8'h12, 8'h34, 8'h56, 1'b0);
        send_byte(8'h24);
        wait_quiet();
    endtask

    task automatic test_random_stream(input int rx_pct, input int res_pct,
                                      input logic [7:0] bp, input logic [7:0] tp,
                                      input int target);
        int stop_at;
        int pick;
        int len;
        logic [7:0] b;
        rx_gap_pct    = rx_pct;
        res_stall_pct = res_pct;
        set_prefixes(bp, tp);
        stop_at = sent_items + target;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(3) != 0)
                return_to_idle();
            pick = $urandom_range(99);
            if (pick < 35 || (pick < 60 && bin_prefix == txt_prefix))
            begin
                b = $urandom_range(1) ? CHR_C : CHR_B;
                send_binary(b, 8'($urandom), $urandom_range(1) ? CHR_1 : 8'($urandom),
                            8'($urandom), $urandom_range(7) == 0);
            end
            else if (pick < 60)
            begin
                // mostly short texts, now and then long enough to fill the buffer
                len = ($urandom_range(5) == 0) ? $urandom_range(60, 66) : $urandom_range(12);
                send_text(len);
            end
            else if (pick < 80)
                send_byte(8'($urandom));
            else if (pick < 90)
            begin
                send_byte(bin_prefix);
                do b = 8'($urandom); while (b == CHR_C || b == CHR_B);
                send_byte(b);
            end
            else
            begin
                // truncated packet, left for the next sequence to run into
                send_byte(bin_prefix);
                send_byte($urandom_range(1) ? CHR_C : CHR_B);
                len = $urandom_range(3);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom));
            end
        end
        return_to_idle();
        wait_quiet();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_BINARY_PREFIX;
        cfg_ch.data    = '0;
        sent_items     = 0;
        rx_gap_pct     = 8;
        res_stall_pct  = 88;
        bin_prefix     = BINARY_PREFIX_RST;
        txt_prefix     = TEXT_PREFIX_RST;
        go_idle();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_binary_packets();
        test_packet_errors();
        test_text_commands();
        test_equal_prefixes();
        test_random_stream(8, 88, 8'h00, 8'hFF, 120);
        test_random_stream(88, 8, 8'hFF, 8'h00, 120);
        test_random_stream(0, 0, 8'($urandom), 8'($urandom), 120);

        if (fail_count == 0)
            $display("uart_command_packet_parser_core: match");
        else
            $display("uart_command_packet_parser_core: mismatch");
        $finish;
    end

endmodule
